// File: design/tdpk_pkg.sv
package tdpk_pkg;

    localparam int NUM_BITS = 4;
    localparam int HALF     = NUM_BITS / 2;
    localparam int HALF_N   = (HALF > 0) ? HALF : 1;
    localparam int LEVEL_W  = $clog2(NUM_BITS + 1);
    localparam int THR_W    = 9;
    localparam int MAG_MAX  = 255;

    typedef logic [THR_W-1:0] thr_t;
    typedef thr_t [HALF_N-1:0] thr_arr_t;
    typedef logic [NUM_BITS-1:0] code_t;
    typedef logic [LEVEL_W-1:0] level_t;

    // smallest |d| at which step j of the level curve is reached, 256 if never
    function automatic thr_t step_threshold(input int j);
        longint h;
        longint lhs;
        longint rhs;
        thr_t   res;
        h   = 2 * j + 1;
        rhs = 40000 * h * h;
        res = thr_t'(MAG_MAX + 1);
        for (int m = MAG_MAX; m >= 0; m--) begin
            lhs = 9 * longint'(m) * longint'(m) * (4 * HALF * HALF - h * h);
            if (lhs >= rhs) begin
                res = thr_t'(m);
            end
        end
        return res;
    endfunction

    function automatic thr_arr_t build_thresholds();
        thr_arr_t t;
        for (int j = 0; j < HALF_N; j++) begin
            t[j] = (j < HALF) ? step_threshold(j) : thr_t'(MAG_MAX + 1);
        end
        return t;
    endfunction

    localparam thr_arr_t LEVEL_THR = build_thresholds();

endpackage

// File: design/tdpk_level.sv
module tdpk_level
    import tdpk_pkg::*;
(
    input  logic [7:0] point_a_value,
    input  logic [7:0] point_b_value,
    output code_t      code
);

    logic [8:0] diff;
    logic       neg;
    logic [7:0] mag;
    level_t     offset;
    level_t     level;

    always_comb begin
        diff   = {1'b0, point_a_value} - {1'b0, point_b_value};
        neg    = diff[8];
        mag    = neg ? (point_b_value - point_a_value) : diff[7:0];
        offset = '0;
        for (int j = 0; j < HALF; j++) begin
            if ({1'b0, mag} >= LEVEL_THR[j]) begin
                offset = offset + level_t'(1);
            end
        end
        level = neg ? (level_t'(HALF) - offset) : (level_t'(HALF) + offset);
        for (int i = 0; i < NUM_BITS; i++) begin
            code[i] = (level_t'(i) < level);
        end
    end

endmodule

// File: design/tdpk_pack.sv
module tdpk_pack
    import tdpk_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       advance,
    input  logic       item_valid,
    input  code_t      code,
    input  logic       last_pair,
    output logic       out_valid,
    output logic [7:0] packed_byte,
    output logic       last_byte
);

    logic [7:0] acc_reg,   acc_next;
    logic [3:0] fill_reg,  fill_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg,  byte_next;
    logic       last_reg,  last_next;

    logic [4:0] used;
    logic [7:0] code_ext;
    logic [7:0] merged;
    logic [3:0] fill_new;
    logic       emit;

    always_comb begin
        code_ext = 8'(code);
        used     = 5'(fill_reg) + 5'(NUM_BITS);
        if (used <= 5'd8) begin
            merged   = acc_reg | (code_ext << (5'd8 - used));
            fill_new = used[3:0];
        end else begin
            merged   = acc_reg | (code_ext >> (used - 5'd8));
            fill_new = 4'd8;
        end
        emit = (fill_new >= 4'd8) || last_pair;

        acc_next   = acc_reg;
        fill_next  = fill_reg;
        valid_next = valid_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        if (advance) begin
            valid_next = item_valid && emit;
            if (item_valid) begin
                byte_next = merged;
                last_next = last_pair;
                if (emit) begin
                    acc_next  = '0;
                    fill_next = '0;
                end else begin
                    acc_next  = merged;
                    fill_next = fill_new;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg   <= '0;
            fill_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            acc_reg   <= acc_next;
            fill_reg  <= fill_next;
            valid_reg <= valid_next;
        end
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

    assign out_valid   = valid_reg;
    assign packed_byte = byte_reg;
    assign last_byte   = last_reg;

    a_fill_below_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg < 4'd8)
        else $error("fill count reached a full byte without emission");

    a_emit_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> (fill_reg == 4'd0 && acc_reg == 8'd0))
        else $error("accumulator not cleared behind a pending byte");

    a_free_bits_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (acc_reg & (8'hFF >> fill_reg)) == 8'd0)
        else $error("accumulator has bits set below the fill point");

    a_hold_when_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> (fill_reg == $past(fill_reg) && acc_reg == $past(acc_reg)))
        else $error("packing state moved while output stalled");

endmodule

// File: design/thermometer_diff_descriptor_packer.sv
// channel | ports                      | tdata (low bit up)                  | tuser/tlast
// input   | s_tvalid s_tready s_tdata  | point_a_value[7:0] point_b_value    | tlast: last_pair
// output  | m_tvalid m_tready m_tdata  | packed_byte[7:0]                    | tlast: last_byte
//
// one pair is taken every cycle while the output is not stalled
// the pair sits in an input register, then level lookup and byte packing run
// combinationally into the output register
// reset (aresetn low at a clock edge) empties both stages and the partial byte
// a stalled output holds the pipe; one new pair can still enter the empty input register
module thermometer_diff_descriptor_packer
    import tdpk_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // point_a_value[7:0], point_b_value[15:8]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // packed_byte[7:0]
    output logic        m_tlast
);

    logic       in_valid_reg, in_valid_next;
    logic [7:0] a_reg,        a_next;
    logic [7:0] b_reg,        b_next;
    logic       last_reg,     last_next;
    logic       advance;
    code_t      code;

    assign advance  = !m_tvalid || m_tready;
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        last_next     = last_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
            if (s_tvalid) begin
                a_next    = s_tdata[7:0];
                b_next    = s_tdata[15:8];
                last_next = s_tlast;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
        a_reg    <= a_next;
        b_reg    <= b_next;
        last_reg <= last_next;
    end

    tdpk_level u_level (
        .point_a_value (a_reg),
        .point_b_value (b_reg),
        .code          (code)
    );

    tdpk_pack u_pack (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (advance),
        .item_valid  (in_valid_reg),
        .code        (code),
        .last_pair   (last_reg),
        .out_valid   (m_tvalid),
        .packed_byte (m_tdata),
        .last_byte   (m_tlast)
    );

endmodule

// File: sim/tb_thermometer_diff_descriptor_packer.sv
`timescale 1ns / 1ps

module tb_thermometer_diff_descriptor_packer;
    import tdpk_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int SHOW_LIMIT  = 10;

    typedef struct packed {
        logic [7:0] packed_byte;
        logic       last_byte;
    } desc_byte_t;

    class descriptor_board;
        int unsigned acc_bits;
        int unsigned filled_bits;
        desc_byte_t  pending_bytes[$];
        int          failures;

        function new();
            acc_bits    = 0;
            filled_bits = 0;
            failures    = 0;
        endfunction

        // number of curve steps reached for |d| = mag
        function int unsigned level_steps(input int unsigned mag);
            int unsigned cnt;
            longint      h;
            longint      lhs;
            longint      rhs;
            cnt = 0;
            for (int j = 1; j <= HALF; j++) begin
                h   = 2 * j - 1;
                lhs = 9 * longint'(mag) * longint'(mag) * (4 * HALF * HALF - h * h);
                rhs = 40000 * h * h;
                if (lhs >= rhs) begin
                    cnt++;
                end
            end
            return cnt;
        endfunction

        function void note_pair(input logic [7:0] a, input logic [7:0] b, input logic last);
            int unsigned level;
            int unsigned code;
            int unsigned used;
            desc_byte_t  item;
            if (a >= b) begin
                level = HALF + level_steps(a - b);
            end else begin
                level = HALF - level_steps(b - a);
            end
            if (level > 8) begin
                level = 8;
            end
            code = ((32'd1 << level) - 1) & ((32'd1 << NUM_BITS) - 1);
            used = filled_bits + NUM_BITS;
            if (used <= 8) begin
                acc_bits |= code << (8 - used);
            end else begin
                acc_bits |= code >> (used - 8);
                used = 8;
            end
            acc_bits &= 32'hFF;
            filled_bits = used;
            if (filled_bits >= 8 || last) begin
                item.packed_byte = acc_bits[7:0];
                item.last_byte   = last;
                pending_bytes.insert(pending_bytes.size(), item);
                acc_bits    = 0;
                filled_bits = 0;
            end
        endfunction

        function void check_byte(input logic [7:0] data, input logic last);
            desc_byte_t want;
            if (pending_bytes.size() == 0) begin
                failures++;
                if (failures <= SHOW_LIMIT) begin
                    $display("unexpected output beat: byte %02h last %0d", data, last);
                end
                return;
            end
            want = pending_bytes.pop_front();
            if (want.packed_byte !== data || want.last_byte !== last) begin
                failures++;
                if (failures <= SHOW_LIMIT) begin
                    $display("mismatch: expected byte %02h last %0d, got byte %02h last %0d",
                             want.packed_byte, want.last_byte, data, last);
                end
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    descriptor_board board = new();
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_cycles  = 0;

    thermometer_diff_descriptor_packer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                board.note_pair(s_tdata[7:0], s_tdata[15:8], s_tlast);
            end
            if (m_tvalid && m_tready) begin
                board.check_byte(m_tdata, m_tlast);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    task automatic send_pair(input logic [7:0] a, input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, a};
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
    endtask

    // descriptors of random length, mostly short, with half the pairs close enough to span the curve steps
    task automatic send_descriptors(input int pairs);
        int sent;
        int len;
        int a;
        int b;
        sent = 0;
        while (sent < pairs) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 16);
            for (int i = 0; i < len; i++) begin
                a = $urandom_range(255);
                if ($urandom_range(1) == 0) begin
                    b = $urandom_range(255);
                end else begin
                    b = a + int'($urandom_range(200)) - 100;
                    if (b < 0) b = 0;
                    if (b > 255) b = 255;
                end
                send_pair(a[7:0], b[7:0], i == len - 1);
                sent++;
            end
        end
    endtask

    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        m_tready <= 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // extremes, step edges on both signs, full and partial bytes on the last pair
        send_pair(8'd0,   8'd255, 1'b0);
        send_pair(8'd255, 8'd0,   1'b1);
        send_pair(8'd128, 8'd128, 1'b1);
        send_pair(8'd0,   8'd0,   1'b0);
        send_pair(8'd255, 8'd255, 1'b0);
        send_pair(8'd117, 8'd100, 1'b0);
        send_pair(8'd118, 8'd100, 1'b0);
        send_pair(8'd100, 8'd117, 1'b0);
        send_pair(8'd100, 8'd118, 1'b1);
        send_pair(8'd175, 8'd100, 1'b0);
        send_pair(8'd176, 8'd100, 1'b0);
        send_pair(8'd100, 8'd175, 1'b0);
        send_pair(8'd100, 8'd176, 1'b0);
        send_pair(8'd170, 8'd85,  1'b1);
        send_pair(8'd85,  8'd170, 1'b0);
        send_pair(8'd1,   8'd0,   1'b0);
        send_pair(8'd0,   8'd1,   1'b0);
        send_pair(8'd254, 8'd127, 1'b1);

        send_idle_pct = 27;
        recv_idle_pct = 51;
        send_descriptors(560);
        send_idle_pct = 51;
        recv_idle_pct = 27;
        send_descriptors(560);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_descriptors(560);
        s_tvalid <= 1'b0;

        while (board.pending_bytes.size() != 0) begin
            @(posedge aclk);
        end
        repeat (10) @(posedge aclk);
        if (board.failures == 0 && board.pending_bytes.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
design/tdpk_pkg.sv
design/tdpk_level.sv
design/tdpk_pack.sv
design/thermometer_diff_descriptor_packer.sv
sim/tb_thermometer_diff_descriptor_packer.sv
